[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TTV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define TTV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define TTV_ASSERT(lbl, clk, rst_n, prop)
`define TTV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/ttv_pkg.sv]
package ttv_pkg;

	localparam int MAG_W  = 30;
	localparam int SUM_W  = 62;
	localparam int ROOT_W = 31;
	localparam int Q_W    = 15;
	localparam int NUM_W  = 46;
	localparam int WM_W   = 51;
	localparam int FRONT_STAGES = 8;
	localparam int LATENCY = FRONT_STAGES + ROOT_W + Q_W + 2;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic        [31:0] a_uv;
		logic        [31:0] b_uv;
		logic        [31:0] c_uv;
	} item_t;

	typedef struct packed {
		logic signed [15:0] tan_x;
		logic signed [15:0] tan_y;
		logic signed [15:0] tan_z;
		logic               degenerate;
	} result_t;

	typedef struct packed {
		logic                      degen;
		logic [2:0]                neg;
		logic [2:0][MAG_W-1:0]     mag;
	} side_t;

	typedef struct packed {
		logic                      degen;
		logic [2:0]                neg;
		logic [2:0][Q_W-1:0]       quo;
	} quo_t;

endpackage

[hw/rtl/ttv_front.sv]
module ttv_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  ttv_pkg::item_t              item,
	output logic                        out_valid,
	output ttv_pkg::side_t              side,
	output logic [ttv_pkg::SUM_W-1:0]   sumsq
);

	logic [8:1] vld_s;

	logic signed [16:0] s1_s1, t1_s1, s2_s1, t2_s1;
	logic signed [32:0] p_s1 [3];
	logic signed [32:0] q_s1 [3];

	logic signed [49:0] tp_s2 [3];
	logic signed [49:0] tq_s2 [3];
	logic signed [33:0] d1_s2, d2_s2;

	logic signed [51:0] w_s3 [3];
	logic               detz_s3, detneg_s3;

	logic [ttv_pkg::WM_W-1:0]  mag_s4 [3];
	logic [2:0]                neg_s4;
	logic                      degen_s4;

	logic [ttv_pkg::WM_W-1:0]  mag_s5 [3];
	logic [4:0]                sh_s5;
	logic [2:0]                neg_s5;
	logic                      degen_s5;

	logic [2:0][ttv_pkg::MAG_W-1:0] mag_s6, mag_s7, mag_s8;
	logic [2:0]                neg_s6, neg_s7, neg_s8;
	logic                      degen_s6, degen_s7, degen_s8;

	logic [59:0]               sq_s7 [3];
	logic [ttv_pkg::SUM_W-1:0] sum_s8;

	logic signed [16:0] ua, va, ub, vb, uc, vc;
	logic signed [32:0] pa [3], pb [3], pc [3];
	logic signed [34:0] det;
	logic [ttv_pkg::WM_W-1:0] orv;
	logic [5:0] pos;

	assign ua = $signed({1'b0, item.a_uv[15:0]});
	assign va = $signed({1'b0, item.a_uv[31:16]});
	assign ub = $signed({1'b0, item.b_uv[15:0]});
	assign vb = $signed({1'b0, item.b_uv[31:16]});
	assign uc = $signed({1'b0, item.c_uv[15:0]});
	assign vc = $signed({1'b0, item.c_uv[31:16]});

	assign pa[0] = 33'(item.a_x);
	assign pa[1] = 33'(item.a_y);
	assign pa[2] = 33'(item.a_z);
	assign pb[0] = 33'(item.b_x);
	assign pb[1] = 33'(item.b_y);
	assign pb[2] = 33'(item.b_z);
	assign pc[0] = 33'(item.c_x);
	assign pc[1] = 33'(item.c_y);
	assign pc[2] = 33'(item.c_z);

	assign det = 35'(d1_s2) - 35'(d2_s2);

	// Leading one of the largest magnitude picks the scaling shift.
	assign orv = mag_s4[0] | mag_s4[1] | mag_s4[2];
	always_comb begin
		pos = '0;
		for (int i = 0; i < ttv_pkg::WM_W; i++) begin
			if (orv[i]) begin
				pos = 6'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[7:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		s1_s1 <= ub - ua;
		t1_s1 <= vb - va;
		s2_s1 <= uc - ua;
		t2_s1 <= vc - va;
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= pb[i] - pa[i];
			q_s1[i] <= pc[i] - pa[i];
		end

		for (int i = 0; i < 3; i++) begin
			tp_s2[i] <= 50'(t2_s1 * p_s1[i]);
			tq_s2[i] <= 50'(t1_s1 * q_s1[i]);
		end
		d1_s2 <= 34'(s1_s1 * t2_s1);
		d2_s2 <= 34'(s2_s1 * t1_s1);

		for (int i = 0; i < 3; i++) begin
			w_s3[i] <= 52'(tp_s2[i]) - 52'(tq_s2[i]);
		end
		detz_s3   <= (det == '0);
		detneg_s3 <= det[34];

		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= w_s3[i][51] ? ttv_pkg::WM_W'(-w_s3[i]) : ttv_pkg::WM_W'(w_s3[i]);
			neg_s4[i] <= w_s3[i][51] ^ detneg_s3;
		end
		degen_s4 <= detz_s3 || ((w_s3[0] == '0) && (w_s3[1] == '0) && (w_s3[2] == '0));

		mag_s5   <= mag_s4;
		sh_s5    <= (pos >= 6'(ttv_pkg::MAG_W)) ? 5'(pos - 6'(ttv_pkg::MAG_W - 1)) : 5'd0;
		neg_s5   <= neg_s4;
		degen_s5 <= degen_s4;

		for (int i = 0; i < 3; i++) begin
			mag_s6[i] <= ttv_pkg::MAG_W'(mag_s5[i] >> sh_s5);
		end
		neg_s6   <= neg_s5;
		degen_s6 <= degen_s5;

		for (int i = 0; i < 3; i++) begin
			sq_s7[i] <= 60'(mag_s6[i]) * 60'(mag_s6[i]);
		end
		mag_s7   <= mag_s6;
		neg_s7   <= neg_s6;
		degen_s7 <= degen_s6;

		sum_s8   <= ttv_pkg::SUM_W'(sq_s7[0]) + ttv_pkg::SUM_W'(sq_s7[1])
			+ ttv_pkg::SUM_W'(sq_s7[2]);
		mag_s8   <= mag_s7;
		neg_s8   <= neg_s7;
		degen_s8 <= degen_s7;
	end

	assign out_valid  = vld_s[8];
	assign side.degen = degen_s8;
	assign side.neg   = neg_s8;
	assign side.mag   = mag_s8;
	assign sumsq      = sum_s8;

endmodule

[hw/rtl/ttv_sqrt.sv]
module ttv_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  ttv_pkg::side_t              in_side,
	input  logic [ttv_pkg::SUM_W-1:0]   radicand,
	output logic                        out_valid,
	output ttv_pkg::side_t              out_side,
	output logic [ttv_pkg::ROOT_W-1:0]  root
);

	localparam int N = ttv_pkg::ROOT_W;

	logic                      vld_s  [0:N];
	ttv_pkg::side_t            side_s [0:N];
	logic [ttv_pkg::SUM_W-1:0] rem_s  [0:N];
	logic [ttv_pkg::SUM_W-1:0] root_s [0:N];

	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;
	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;

	// One result bit per stage, most significant first.
	for (genvar j = 1; j <= N; j++) begin : g_step
		localparam int SH = 2 * (N - j);
		logic [ttv_pkg::SUM_W-1:0] bitv, trial;
		logic                      take;

		assign bitv  = ttv_pkg::SUM_W'(1) << SH;
		assign trial = root_s[j-1] + bitv;
		assign take  = rem_s[j-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			side_s[j] <= side_s[j-1];
			rem_s[j]  <= take ? rem_s[j-1] - trial : rem_s[j-1];
			root_s[j] <= take ? (root_s[j-1] >> 1) + bitv : root_s[j-1] >> 1;
		end
	end

	assign out_valid = vld_s[N];
	assign out_side  = side_s[N];
	assign root      = root_s[N][ttv_pkg::ROOT_W-1:0];

endmodule

[hw/rtl/ttv_div.sv]
module ttv_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  ttv_pkg::side_t              in_side,
	input  logic [ttv_pkg::ROOT_W-1:0]  len,
	output logic                        out_valid,
	output ttv_pkg::quo_t               quo
);

	localparam int N = ttv_pkg::Q_W;
	localparam int DW = ttv_pkg::ROOT_W + 1;

	logic                      vld_s   [0:N];
	logic                      degen_s [0:N];
	logic [2:0]                neg_s   [0:N];
	logic [DW-1:0]             den_s   [0:N];
	logic [ttv_pkg::NUM_W-1:0] rem_s   [0:N][3];
	logic [N-1:0]              q_s     [0:N][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// Numerator mag*32768 + len over 2*len rounds half away from zero.
	always_ff @(posedge clk) begin
		degen_s[0] <= in_side.degen;
		neg_s[0]   <= in_side.neg;
		den_s[0]   <= {len, 1'b0};
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= ttv_pkg::NUM_W'({in_side.mag[i], 15'd0})
				+ ttv_pkg::NUM_W'(len);
			q_s[0][i]   <= '0;
		end
	end

	for (genvar j = 1; j <= N; j++) begin : g_step
		localparam int K = N - j;
		logic [ttv_pkg::NUM_W-1:0] dsh;

		assign dsh = ttv_pkg::NUM_W'(den_s[j-1]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			degen_s[j] <= degen_s[j-1];
			neg_s[j]   <= neg_s[j-1];
			den_s[j]   <= den_s[j-1];
			for (int i = 0; i < 3; i++) begin
				if (rem_s[j-1][i] >= dsh) begin
					rem_s[j][i] <= rem_s[j-1][i] - dsh;
					q_s[j][i]   <= {q_s[j-1][i][N-2:0], 1'b1};
				end else begin
					rem_s[j][i] <= rem_s[j-1][i];
					q_s[j][i]   <= {q_s[j-1][i][N-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quo.degen = degen_s[N];
	assign quo.neg   = neg_s[N];
	assign quo.quo   = {q_s[N][2], q_s[N][1], q_s[N][0]};

endmodule

[hw/rtl/triangle_tangent_vector.sv]
// A result strobes on done once start has passed the front end, square root, divider and final register.
// Throughput: one triangle per cycle; busy is always low and every stage moves each cycle.
// Reset: arst_n clears all valid bits at once, so no stale results strobe afterwards.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module triangle_tangent_vector (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ttv_pkg::item_t   item,
	output logic             done,
	output ttv_pkg::result_t result
);

`include "assert_macros.svh"

	// The front end forms the edges, the unnormalized tangent, its scaling
	// and the squared length over eight stages. The square root then takes
	// one root bit per stage (31 stages), and the three divisions run as
	// parallel restoring lanes, one quotient bit per stage, after a setup
	// stage. A final register applies signs and the degenerate case.
	logic                         fr_valid;
	ttv_pkg::side_t               fr_side;
	logic [ttv_pkg::SUM_W-1:0]    fr_sum;
	logic                         sq_valid;
	ttv_pkg::side_t               sq_side;
	logic [ttv_pkg::ROOT_W-1:0]   sq_root;
	logic                         dv_valid;
	ttv_pkg::quo_t                dv_quo;
	logic                         done_q;
	ttv_pkg::result_t             result_q;
	logic signed [15:0]           tan_c [3];

	assign busy = 1'b0;

	ttv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.item      (item),
		.out_valid (fr_valid),
		.side      (fr_side),
		.sumsq     (fr_sum)
	);

	ttv_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_side   (fr_side),
		.radicand  (fr_sum),
		.out_valid (sq_valid),
		.out_side  (sq_side),
		.root      (sq_root)
	);

	ttv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_side   (sq_side),
		.len       (sq_root),
		.out_valid (dv_valid),
		.quo       (dv_quo)
	);

	// Apply the sign; a degenerate triangle reports the zero vector.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tan_c[i] = dv_quo.neg[i] ? -$signed({1'b0, dv_quo.quo[i]})
				: $signed({1'b0, dv_quo.quo[i]});
			if (dv_quo.degen) begin
				tan_c[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.tan_x      <= tan_c[0];
		result_q.tan_y      <= tan_c[1];
		result_q.tan_z      <= tan_c[2];
		result_q.degenerate <= dv_quo.degen;
	end

	assign done   = done_q;
	assign result = result_q;

	`TTV_ASSERT_IMPL(a_degen_zero, clk, arst_n, done && result.degenerate, (result.tan_x == '0) && (result.tan_y == '0) && (result.tan_z == '0))
	`TTV_ASSERT_IMPL(a_unit_nonzero, clk, arst_n, done && !result.degenerate, (result.tan_x != '0) || (result.tan_y != '0) || (result.tan_z != '0))
	`TTV_ASSERT_IMPL(a_range, clk, arst_n, done, (result.tan_x >= -16'sd16384) && (result.tan_x <= 16'sd16384) && (result.tan_y >= -16'sd16384) && (result.tan_y <= 16'sd16384) && (result.tan_z >= -16'sd16384) && (result.tan_z <= 16'sd16384))
	`TTV_ASSERT_IMPL(a_latency, clk, arst_n, done, $past(start, ttv_pkg::LATENCY))

endmodule

[sim/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Pipeline depth of the block from accept to strobe, used for the final wait.
	localparam int PIPE_CYCLES = 56;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ttv_pkg::item_t item;
	logic done;
	ttv_pkg::result_t result;

	triangle_tangent_vector i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Triangles waiting to be driven, and tangents predicted for accepted ones.
	ttv_pkg::item_t tri_queue[$];
	ttv_pkg::result_t tangent_queue[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;
	// When set, the driver holds off until every predicted tangent has arrived.
	bit drain_req = 1'b0;

	// Appends one triangle to the end of the pending list.
	function automatic void queue_tri(input ttv_pkg::item_t t);
		tri_queue.insert(tri_queue.size(), t);
	endfunction

	// Integer square root by the usual bit-pair method.
	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Predicts the unit tangent of one triangle, rounded to Q1.14.
	function automatic ttv_pkg::result_t unit_tangent(input ttv_pkg::item_t t);
		ttv_pkg::result_t r;
		longint pa[3], pb[3], pc[3];
		longint ua, va, ub, vb, uc, vc, s1, t1, s2, t2, det, w;
		longint unsigned mag[3];
		longint unsigned maxmag, sumsq, len, o;
		bit neg[3];
		int sh;
		pa = '{longint'(t.a_x), longint'(t.a_y), longint'(t.a_z)};
		pb = '{longint'(t.b_x), longint'(t.b_y), longint'(t.b_z)};
		pc = '{longint'(t.c_x), longint'(t.c_y), longint'(t.c_z)};
		ua = t.a_uv[15:0];
		va = t.a_uv[31:16];
		ub = t.b_uv[15:0];
		vb = t.b_uv[31:16];
		uc = t.c_uv[15:0];
		vc = t.c_uv[31:16];
		s1 = ub - ua;
		t1 = vb - va;
		s2 = uc - ua;
		t2 = vc - va;
		det = s1 * t2 - s2 * t1;
		r = '0;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		maxmag = 0;
		for (int i = 0; i < 3; i++) begin
			w = t2 * (pb[i] - pa[i]) - t1 * (pc[i] - pa[i]);
			neg[i] = (w < 0) != (det < 0);
			mag[i] = (w < 0) ? longint'(-w) : longint'(w);
			if (mag[i] > maxmag)
				maxmag = mag[i];
		end
		if (maxmag == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		sh = 0;
		while ((maxmag >> sh) >= (64'd1 << 30))
			sh++;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] >>= sh;
			sumsq += mag[i] * mag[i];
		end
		len = root_floor(sumsq);
		for (int i = 0; i < 3; i++) begin
			o = (mag[i] * 32768 + len) / (2 * len);
			if (o > 16384)
				o = 16384;
			if (neg[i])
				o = -o;
			case (i)
				0: r.tan_x = o[15:0];
				1: r.tan_y = o[15:0];
				default: r.tan_z = o[15:0];
			endcase
		end
		return r;
	endfunction

	// Driver: one beat per triangle, with a randomly drawn idle gap after each accepted triangle.
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else begin
			int wait_cycles;
			wait_cycles = gap_left;
			// A beat is taken at this edge when start was high and busy low.
			if (start && !busy) begin
				tangent_queue.insert(tangent_queue.size(), unit_tangent(item));
				void'(tri_queue.pop_front());
				wait_cycles = $urandom_range(0, 3);
			end
			if (start && busy) begin
				// Hold the beat until it is taken.
			end else if (tri_queue.size() != 0 && wait_cycles == 0
					&& !(drain_req && tangent_queue.size() != 0)) begin
				start <= 1'b1;
				item <= tri_queue[0];
				gap_left <= 0;
			end else begin
				start <= 1'b0;
				gap_left <= (wait_cycles > 0) ? wait_cycles - 1 : 0;
			end
		end
	end

	// Monitor: every strobe is checked against the oldest prediction.
	always @(posedge clk) begin
		ttv_pkg::result_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (tangent_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected tangent beat %p", result);
				end else begin
					want = tangent_queue.pop_front();
					if (result.tan_x !== want.tan_x || result.tan_y !== want.tan_y
							|| result.tan_z !== want.tan_z
							|| result.degenerate !== want.degenerate) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("tangent: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
								want.tan_x, want.tan_y, want.tan_z, want.degenerate,
								result.tan_x, result.tan_y, result.tan_z,
								result.degenerate);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("triangle_tangent_vector: mismatch");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic logic [31:0] rand_uv(input int mode);
		case (mode)
			0: return $urandom;
			1: return {16'($urandom_range(0, 64)), 16'($urandom_range(0, 64))};
			default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
				$urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
		endcase
	endfunction

	function automatic ttv_pkg::item_t rand_triangle();
		ttv_pkg::item_t t;
		int pm, um;
		pm = $urandom_range(0, 3);
		um = $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2);
		t.a_x = rand_coord(pm);
		t.a_y = rand_coord(pm);
		t.a_z = rand_coord(pm);
		t.b_x = rand_coord(pm);
		t.b_y = rand_coord(pm);
		t.b_z = rand_coord(pm);
		t.c_x = rand_coord(pm);
		t.c_y = rand_coord(pm);
		t.c_z = rand_coord(pm);
		t.a_uv = rand_uv(um);
		t.b_uv = rand_uv(um);
		t.c_uv = rand_uv(um);
		// Now and then collapse the texcoords or the edges to hit the degenerate cases.
		case ($urandom_range(0, 19))
			0: t.c_uv = t.b_uv;
			1: begin
				t.b_x = t.a_x;
				t.b_y = t.a_y;
				t.b_z = t.a_z;
				t.c_x = t.a_x;
				t.c_y = t.a_y;
				t.c_z = t.a_z;
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic wait_drained();
		drain_req = 1'b1;
		while (tri_queue.size() != 0 || tangent_queue.size() != 0)
			@(posedge clk);
		drain_req = 1'b0;
	endtask

	initial begin
		ttv_pkg::item_t t;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed triangles: a plain right triangle with unit texcoords.
		t = '0;
		t.b_x = 32'h0001_0000;
		t.c_y = 32'h0001_0000;
		t.b_uv = 32'h0000_FFFF;
		t.c_uv = 32'hFFFF_0000;
		queue_tri(t);
		// Mirrored texcoords flip the sign of the determinant.
		t.b_uv = 32'hFFFF_0000;
		t.c_uv = 32'h0000_FFFF;
		queue_tri(t);
		// Zero determinant: all three texcoords equal.
		t.a_uv = 32'h1234_5678;
		t.b_uv = 32'h1234_5678;
		t.c_uv = 32'h1234_5678;
		queue_tri(t);
		// Zero tangent: all vertices coincide but texcoords are sound.
		t = '0;
		t.a_x = 32'h7FFF_FFFF;
		t.b_x = 32'h7FFF_FFFF;
		t.c_x = 32'h7FFF_FFFF;
		t.b_uv = 32'h0000_FFFF;
		t.c_uv = 32'hFFFF_0000;
		queue_tri(t);
		// Position extremes give the widest edges.
		t = '0;
		t.a_x = 32'h8000_0000;
		t.a_y = 32'h8000_0000;
		t.a_z = 32'h8000_0000;
		t.b_x = 32'h7FFF_FFFF;
		t.b_y = 32'h8000_0000;
		t.b_z = 32'h7FFF_FFFF;
		t.c_x = 32'h8000_0000;
		t.c_y = 32'h7FFF_FFFF;
		t.c_z = 32'h7FFF_FFFF;
		t.a_uv = 32'hFFFF_FFFF;
		t.b_uv = 32'hFFFF_0000;
		t.c_uv = 32'h0000_FFFF;
		queue_tri(t);
		// Tangent along a single axis, both signs, to reach the 16384 output.
		for (int k = 0; k < 6; k++) begin
			t = '0;
			t.b_uv = 32'h0000_0001;
			t.c_uv = 32'h0001_0000;
			case (k % 3)
				0: t.b_x = k < 3 ? 32'h0000_0100 : 32'hFFFF_FF00;
				1: t.b_y = k < 3 ? 32'h0000_0100 : 32'hFFFF_FF00;
				default: t.b_z = k < 3 ? 32'h0000_0100 : 32'hFFFF_FF00;
			endcase
			queue_tri(t);
		end
		// All bits high and all bits low in every field.
		t = '1;
		queue_tri(t);
		t = '0;
		queue_tri(t);
		wait_drained();

		for (int n = 0; n < 1350; n++) begin
			queue_tri(rand_triangle());
			if (n == 700) begin
				wait_drained();
				repeat ($urandom_range(0, 8)) @(posedge clk);
			end
			while (tri_queue.size() > 4)
				@(posedge clk);
		end
		while (tri_queue.size() != 0 || tangent_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_CYCLES + 10) @(posedge clk);
		if (mismatch_count == 0 && tangent_queue.size() == 0)
			$display("triangle_tangent_vector: match");
		else
			$display("triangle_tangent_vector: mismatch");
		$finish;
	end
endmodule
